// ===== rtl/core/bac_pkg.sv =====
package bac_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] amount;
    logic [31:0] alignment;
    logic        commit_granted;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  status;
    logic [31:0] block_offset;
    logic [31:0] used_after;
    logic [31:0] committed_after;
    logic [31:0] commit_bytes;
    logic [31:0] freed_bytes;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_POP_TO,
    OP_CLEAR,
    OP_SET_USED,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] amount;
    logic [31:0] alignment;
    logic        commit_granted;
  } cmd_t;

  localparam logic [2:0] MODE_PUSH     = 3'd0;
  localparam logic [2:0] MODE_POP      = 3'd1;
  localparam logic [2:0] MODE_POP_TO   = 3'd2;
  localparam logic [2:0] MODE_CLEAR    = 3'd3;
  localparam logic [2:0] MODE_SET_USED = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_RESERVE  = 3'd3;
  localparam logic [2:0] ST_REFUSED  = 3'd4;

  localparam logic [1:0] REG_KIND    = 2'd0;
  localparam logic [1:0] REG_BASE    = 2'd1;
  localparam logic [1:0] REG_RESERVE = 2'd2;
  localparam logic [1:0] REG_GRANULE = 2'd3;

  localparam logic [31:0] RESERVE_RST = 32'd65536;
  localparam logic [31:0] GRANULE_RST = 32'd4096;

endpackage

// ===== rtl/core/bac_front.sv =====
module bac_front import bac_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t data,
  output logic     full,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);

  cmd_t       q_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic       wr_en;
  logic       rd_en;
  cmd_t       cls;

  always_comb begin
    cls.amount         = data.amount;
    cls.alignment      = data.alignment;
    cls.commit_granted = data.commit_granted;
    unique case (data.mode)
      MODE_PUSH:     cls.op = OP_PUSH;
      MODE_POP:      cls.op = OP_POP;
      MODE_POP_TO:   cls.op = OP_POP_TO;
      MODE_CLEAR:    cls.op = OP_CLEAR;
      MODE_SET_USED: cls.op = OP_SET_USED;
      default:       cls.op = OP_NOP;
    endcase
  end

  assign full      = cnt_r[1];
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_r] <= cls;
    end
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wr_r <= ~wr_r;
      if (rd_en) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ===== rtl/core/bac_div.sv =====
module bac_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  dvd_r;
  logic [W-1:0]  dvs_r;
  logic [W-1:0]  rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    trial = {rem_r, dvd_r[W-1]};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CW'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[W-2:0], 1'b0};
        rem_r <= diff[W] ? trial[W-1:0] : diff[W-1:0];
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/bac_back.sv =====
module bac_back import bac_pkg::*; #(
  parameter int W = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  output logic        div_start,
  output logic [W-1:0] div_dvd,
  output logic [W-1:0] div_dvs,
  input  logic        div_done,
  input  logic [W-1:0] div_rem,
  output out_item_t   out_data,
  output logic        out_empty,
  input  logic        out_pop
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_PAD, S_CHK, S_RWAIT, S_GROW, S_PWAIT, S_PFIN, S_OUT
  } state_t;

  function automatic logic [W-1:0] cut(input logic [31:0] x);
    logic [63:0] t;
    t = {32'd0, x};
    return t[W-1:0];
  endfunction

  function automatic logic [31:0] o32(input logic [W-1:0] v);
    logic [63:0] t;
    t = '0;
    t[W-1:0] = v;
    return t[31:0];
  endfunction

  state_t    state_r;
  cmd_t      cmd_r;
  logic      kind_r;
  logic [W-1:0] base_r, resv_r, gran_r;
  logic [W-1:0] used_r, comm_r;
  logic [W-1:0] pad_r, need_r, r2_r;
  logic      div_start_r;
  logic [W-1:0] div_dvd_r, div_dvs_r;
  logic      res_gr_r;
  logic [2:0] res_st_r;
  logic [W-1:0] res_off_r, res_cb_r, res_db_r;
  out_item_t out_data_r;
  logic      out_valid_r;

  logic [W-1:0] amt, aln1, addr, adv, need, add, grow, want, newu, mark;
  logic      ovf, want_ok;

  always_comb begin
    amt  = cut(cmd_r.amount);
    aln1 = (cut(cmd_r.alignment) == '0) ? W'(1) : cut(cmd_r.alignment);
    addr = base_r + used_r;
    adv  = pad_r + amt;
    need = used_r + adv;
    ovf  = (pad_r > ~amt) || (used_r > ~adv);
    add  = gran_r - r2_r;
    // round need up to the granule, clamped to the reserve
    if (r2_r == '0) grow = need_r;
    else if (need_r > ~add) grow = resv_r;
    else grow = need_r + add;
    if (grow > resv_r) grow = resv_r;
    // used rounded up for decommit
    want_ok = (r2_r == '0) || !(used_r > ~add);
    want    = (r2_r == '0) ? used_r : used_r + add;
    mark = (cmd_r.op == OP_POP) ? used_r - ((amt > used_r) ? used_r : amt) : amt;
    newu = (mark < used_r) ? mark : used_r;
  end

  assign cmd_take  = (state_r == S_IDLE) && cmd_valid;
  assign div_start = div_start_r;
  assign div_dvd   = div_dvd_r;
  assign div_dvs   = div_dvs_r;
  assign out_data  = out_data_r;
  assign out_empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      kind_r      <= 1'b0;
      base_r      <= '0;
      resv_r      <= cut(RESERVE_RST);
      gran_r      <= cut(GRANULE_RST);
      used_r      <= '0;
      comm_r      <= '0;
    end else begin
      div_start_r <= 1'b0;
      if (out_pop && out_valid_r && state_r != S_OUT) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KIND:    kind_r <= cfg_wdata[0];
          REG_BASE:    base_r <= cut(cfg_wdata);
          REG_RESERVE: resv_r <= cut(cfg_wdata);
          REG_GRANULE: gran_r <= cut(cfg_wdata);
          default:     ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          res_gr_r  <= 1'b1;
          res_st_r  <= ST_OK;
          res_off_r <= '0;
          res_cb_r  <= '0;
          res_db_r  <= '0;
          r2_r      <= '0;
          unique case (cmd_r.op)
            OP_PUSH: begin
              div_start_r <= 1'b1;
              div_dvd_r   <= addr;
              div_dvs_r   <= aln1;
              state_r     <= S_PAD;
            end
            OP_POP, OP_POP_TO: begin
              used_r <= newu;
              if (kind_r && gran_r != '0) begin
                div_start_r <= 1'b1;
                div_dvd_r   <= newu;
                div_dvs_r   <= gran_r;
                state_r     <= S_PWAIT;
              end else begin
                state_r <= S_PFIN;
              end
            end
            OP_CLEAR: begin
              used_r  <= '0;
              state_r <= S_OUT;
            end
            OP_SET_USED: begin
              if (amt < used_r) used_r <= amt;
              state_r <= S_OUT;
            end
            default: begin
              res_gr_r <= 1'b0;
              state_r  <= S_OUT;
            end
          endcase
        end
        S_PAD: begin
          if (div_done) begin
            pad_r   <= (div_rem == '0) ? '0 : aln1 - div_rem;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          res_gr_r <= 1'b0;
          state_r  <= S_OUT;
          if (ovf) begin
            res_st_r <= ST_OVERFLOW;
          end else if (amt == '0) begin
            res_st_r <= ST_ZERO;
          end else if (need > resv_r) begin
            res_st_r <= ST_RESERVE;
          end else if (kind_r && need > comm_r) begin
            need_r <= need;
            if (gran_r != '0) begin
              div_start_r <= 1'b1;
              div_dvd_r   <= need;
              div_dvs_r   <= gran_r;
              state_r     <= S_RWAIT;
            end else begin
              state_r <= S_GROW;
            end
          end else begin
            res_gr_r  <= 1'b1;
            res_off_r <= used_r + pad_r;
            used_r    <= need;
          end
        end
        S_RWAIT: begin
          if (div_done) begin
            r2_r    <= div_rem;
            state_r <= S_GROW;
          end
        end
        S_GROW: begin
          if (cmd_r.commit_granted) begin
            res_gr_r  <= 1'b1;
            res_cb_r  <= grow - comm_r;
            res_off_r <= used_r + pad_r;
            comm_r    <= grow;
            used_r    <= need_r;
          end else begin
            res_st_r <= ST_REFUSED;
          end
          state_r <= S_OUT;
        end
        S_PWAIT: begin
          if (div_done) begin
            r2_r    <= div_rem;
            state_r <= S_PFIN;
          end
        end
        S_PFIN: begin
          if (kind_r && want_ok && want < comm_r) begin
            res_db_r <= comm_r - want;
            comm_r   <= want;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_pop) begin
            out_data_r.granted         <= res_gr_r;
            out_data_r.status          <= res_st_r;
            out_data_r.block_offset    <= o32(res_off_r);
            out_data_r.used_after      <= o32(used_r);
            out_data_r.committed_after <= kind_r ? o32(comm_r) : o32(resv_r);
            out_data_r.commit_bytes    <= o32(res_cb_r);
            out_data_r.freed_bytes     <= o32(res_db_r);
            out_valid_r                <= 1'b1;
            state_r                    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/bump_allocator_with_commit.sv =====
// channel  direction  transfer when           payload
// in       input      in_push & !in_full      in_data (in_item_t)
// out      output     out_pop & !out_empty    out_data (out_item_t)
// cfg      input      cfg_we                  cfg_index, cfg_wdata
//
// a push that grows the watermark with a granule takes two serial remainders of
// one bit a cycle in the shared divider; growth with no granule, other pushes and
// dynamic pops with a granule take one remainder, other pops and the rest none
// a two-entry command queue takes new transfers while the back end works
// synchronous active-low reset; no clearing pass
// a result held on the outputs stalls the back end only, not the input queue
module bump_allocator_with_commit import bac_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_data,
  output logic        in_full,
  output logic        out_empty,
  output out_item_t   out_data,
  input  logic        out_pop,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cmd_t                   cmd;
  logic                   cmd_valid;
  logic                   cmd_take;
  logic                   div_start;
  logic                   div_done;
  logic [OFFSET_BITS-1:0] div_dvd, div_dvs, div_rem;

  bac_front u_front (
    .clk, .rst_n,
    .push(in_push), .data(in_data), .full(in_full),
    .cmd_valid, .cmd, .cmd_take
  );

  bac_div #(.W(OFFSET_BITS)) u_div (
    .clk, .rst_n,
    .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .rem(div_rem)
  );

  bac_back #(.W(OFFSET_BITS)) u_back (
    .clk, .rst_n,
    .cfg_we, .cfg_index, .cfg_wdata,
    .cmd_valid, .cmd, .cmd_take,
    .div_start, .div_dvd, .div_dvs, .div_done, .div_rem,
    .out_data, .out_empty, .out_pop
  );

endmodule

// ===== rtl/core/bac_checker.sv =====
module bac_checker import bac_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_data
);

  a_reset: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.granted |-> out_data.status == ST_OK)
    else $error("granted result with error status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status != ST_OK |->
      out_data.block_offset == '0 && out_data.commit_bytes == '0)
    else $error("refused push reports a block");

  a_nogrant: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_data.granted |->
      out_data.commit_bytes == '0 && out_data.freed_bytes == '0)
    else $error("refused operation moved the watermark");

endmodule

bind bump_allocator_with_commit bac_checker u_chk (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_data
);

// ===== tb/sv/tb_bump_allocator_with_commit.sv =====
`timescale 1ns / 100ps

module tb_bump_allocator_with_commit;
  import bac_pkg::*;

  class alloc_scoreboard;
    logic        kind;
    logic [31:0] base, reserve, granule, used, committed;
    out_item_t   pending[$];
    int          mismatches;

    function void clear_state();
      kind = 1'b0;
      base = '0;
      reserve = RESERVE_RST;
      granule = GRANULE_RST;
      used = '0;
      committed = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_KIND:    kind = val[0];
        REG_BASE:    base = val;
        REG_RESERVE: reserve = val;
        REG_GRANULE: granule = val;
        default: ;
      endcase
    endfunction

    // round v up to granule g; ok is false on overflow
    function logic [31:0] round_up(logic [31:0] v, logic [31:0] g, output bit ok);
      logic [32:0] sum;
      logic [31:0] r;
      ok = 1'b1;
      if (g == 0) return v;
      r = v % g;
      if (r == 0) return v;
      sum = {1'b0, v} + {1'b0, g - r};
      if (sum[32]) begin
        ok = 1'b0;
        return v;
      end
      return sum[31:0];
    endfunction

    function logic [31:0] shrink_to(logic [31:0] mark);
      logic [31:0] want;
      bit ok;
      shrink_to = '0;
      if (mark < used) used = mark;
      if (kind) begin
        want = round_up(used, granule, ok);
        if (ok && want < committed) begin
          shrink_to = committed - want;
          committed = want;
        end
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t   r;
      logic [31:0] al, addr, pad, grow;
      logic [32:0] adv, need;
      bit ok;
      r = '0;
      case (it.mode)
        MODE_PUSH: begin
          al = (it.alignment == 0) ? 32'd1 : it.alignment;
          addr = base + used;
          pad = (addr % al == 0) ? 32'd0 : al - addr % al;
          adv = {1'b0, pad} + {1'b0, it.amount};
          need = {1'b0, used} + adv;
          if (adv[32] || need[32]) r.status = ST_OVERFLOW;
          else if (it.amount == 0) r.status = ST_ZERO;
          else if (need[31:0] > reserve) r.status = ST_RESERVE;
          else if (kind && need[31:0] > committed) begin
            grow = round_up(need[31:0], granule, ok);
            if (!ok || grow > reserve) grow = reserve;
            if (it.commit_granted) begin
              r.commit_bytes = grow - committed;
              committed = grow;
              r.block_offset = used + pad;
              used = need[31:0];
              r.granted = 1'b1;
            end else r.status = ST_REFUSED;
          end else begin
            r.block_offset = used + pad;
            used = need[31:0];
            r.granted = 1'b1;
          end
        end
        MODE_POP: begin
          r.freed_bytes = shrink_to(used - ((it.amount > used) ? used : it.amount));
          r.granted = 1'b1;
        end
        MODE_POP_TO: begin
          r.freed_bytes = shrink_to(it.amount);
          r.granted = 1'b1;
        end
        MODE_CLEAR: begin
          used = '0;
          r.granted = 1'b1;
        end
        MODE_SET_USED: begin
          if (it.amount < used) used = it.amount;
          r.granted = 1'b1;
        end
        default: ;
      endcase
      r.used_after = used;
      r.committed_after = kind ? committed : reserve;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_push, in_full, out_empty, out_pop, cfg_we;
  in_item_t    in_data;
  out_item_t   out_data;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  alloc_scoreboard sb;
  bit quiet_tx, quiet_rx;
  int rx_hold;

  bump_allocator_with_commit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // accepted items go to the scoreboard; popped results are checked against it
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) sb.note_input(in_data);
    if (rst_n && out_pop && !out_empty) sb.check_result(out_data);
  end

  // receiver: random stalls, plus an explicit hold-off
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_pop <= 1'b0;
    end else out_pop <= quiet_rx || ($urandom_range(99) >= 7);
  end

  // push stays high after the last transfer until the next idle cycle or drain
  task automatic send(logic [2:0] mode, logic [31:0] amt, logic [31:0] al, logic cg);
    in_item_t it;
    while (!quiet_tx && $urandom_range(99) < 7) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    it.mode = mode;
    it.amount = amt;
    it.alignment = al;
    it.commit_granted = cg;
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic drain();
    int i;
    in_push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    for (i = 0; i < 80; i++) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_amount();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return 0;
      default: return $urandom_range(3000);
    endcase
  endfunction

  function automatic logic [31:0] pick_align();
    case ($urandom_range(7))
      0: return $urandom();
      1: return 0;
      2: return $urandom_range(1, 100);
      default: return 32'd1 << $urandom_range(12);
    endcase
  endfunction

  task automatic random_burst(int n);
    int k;
    logic [2:0] m;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: m = MODE_PUSH;
        11, 12, 13: m = MODE_POP;
        14, 15: m = MODE_POP_TO;
        16: m = MODE_CLEAR;
        17, 18: m = MODE_SET_USED;
        default: m = 3'($urandom_range(5, 7));
      endcase
      send(m, (m == MODE_POP_TO || m == MODE_SET_USED) ?
           32'($urandom_range(sb.used + 100)) : pick_amount(),
           pick_align(), $urandom_range(9) != 0);
    end
  endtask

  initial begin
    int ph;
    sb = new();
    sb.clear_state();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rx_hold = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default static region
    send(MODE_PUSH, 0, 0, 1'b1);
    send(MODE_PUSH, 100, 0, 1'b1);
    send(MODE_PUSH, 8, 64, 1'b1);
    send(MODE_PUSH, 32'hFFFF_FFFF, 1, 1'b1);
    send(MODE_PUSH, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1);
    send(MODE_PUSH, 70000, 1, 1'b1);
    send(MODE_POP, 50, 0, 1'b0);
    send(MODE_POP, 32'hFFFF_FFFF, 0, 1'b0);
    send(MODE_SET_USED, 0, 0, 1'b0);
    send(MODE_POP_TO, 32'hFFFF_FFFF, 0, 1'b0);
    send(MODE_CLEAR, 0, 0, 1'b0);
    send(3'd7, 5, 5, 1'b1);
    drain();
    // dynamic: growth, refusal, decommit, rounding overflow
    write_cfg(REG_KIND, 32'd1);
    write_cfg(REG_BASE, 32'h0000_0003);
    write_cfg(REG_RESERVE, 32'hFFFF_FFFF);
    write_cfg(REG_GRANULE, 32'h8000_0000);
    send(MODE_PUSH, 10, 16, 1'b0);
    send(MODE_PUSH, 10, 16, 1'b1);
    send(MODE_PUSH, 32'h9000_0000, 1, 1'b1);
    send(MODE_POP, 32'h1000_0000, 0, 1'b0);
    send(MODE_POP_TO, 5, 0, 1'b0);
    send(MODE_SET_USED, 0, 0, 1'b0);
    send(MODE_CLEAR, 0, 0, 1'b0);
    send(MODE_PUSH, 1, 32'h8000_0000, 1'b1);
    drain();

    for (ph = 0; ph < 10; ph++) begin
      write_cfg(REG_KIND, ph % 2);
      write_cfg(REG_BASE, ph == 3 ? 32'hFFFF_FFFF : 32'($urandom_range(255)));
      write_cfg(REG_RESERVE, ph == 4 ? 32'd0 : ph == 5 ? 32'hFFFF_FFFF :
                32'($urandom_range(1000, 70000)));
      write_cfg(REG_GRANULE, ph == 2 ? 32'd0 : ph == 7 ? 32'hFFFF_FFFF :
                32'd1 << $urandom_range(12));
      if (ph == 1) begin
        rx_hold = 300;
        random_burst(20);
      end
      quiet_tx = (ph == 6);
      quiet_rx = (ph == 6);
      random_burst(150);
      quiet_tx = 1'b0;
      quiet_rx = 1'b0;
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
